// ===== hw/rtl/dfsl_pkg.sv =====
// Shared constants and types for the depth-first labeler.
`timescale 1ns / 1ps
package dfsl_pkg;

  localparam int MAX_VERTICES = 32;
  localparam int VTX_W        = $clog2(MAX_VERTICES);
  localparam int CNT_W        = $clog2(MAX_VERTICES + 1);
  localparam int EDGE_W       = 32;
  localparam int LABEL_W      = 6;
  localparam int CFG_DATA_W   = 6;
  localparam int CFG_IDX_W    = 1;

  localparam logic [CFG_IDX_W-1:0] CFG_VERTEX_COUNT = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_START_VERTEX = 1'b1;

  localparam logic MODE_LOAD   = 1'b0;
  localparam logic MODE_SEARCH = 1'b1;

  typedef struct packed {
    logic [VTX_W-1:0] v;
    logic [CNT_W-1:0] nx;
  } frame_t;

  typedef struct packed {
    logic              load;
    logic              search;
    logic [VTX_W-1:0]  row;
    logic [EDGE_W-1:0] edges;
    logic [CNT_W-1:0]  n;
    logic [VTX_W-1:0]  root;
  } walk_cmd_t;

endpackage

// ===== hw/rtl/dfsl_req_if.sv =====
// Request channel: row loads and search requests.
`timescale 1ns / 1ps
interface dfsl_req_if;
  import dfsl_pkg::*;

  logic              valid;
  logic              ready;
  logic              mode;
  logic [4:0]        row_index;
  logic [EDGE_W-1:0] row_edges;

  modport source (output valid, mode, row_index, row_edges, input ready);
  modport sink   (input valid, mode, row_index, row_edges, output ready);
endinterface

// ===== hw/rtl/dfsl_lbl_if.sv =====
// Label channel: one depth label per vertex in use.
`timescale 1ns / 1ps
interface dfsl_lbl_if;
  import dfsl_pkg::*;

  logic               valid;
  logic               ready;
  logic [4:0]         vertex_id;
  logic [LABEL_W-1:0] depth_label;
  logic               last_label;

  modport source (output valid, vertex_id, depth_label, last_label, input ready);
  modport sink   (input valid, vertex_id, depth_label, last_label, output ready);
endinterface

// ===== hw/rtl/dfsl_walk.sv =====
// Walk engine: adjacency, stack and label memories with the depth-first sequencer.
`timescale 1ns / 1ps
module dfsl_walk (
  input  logic                         clk,
  input  logic                         rst,
  input  dfsl_pkg::walk_cmd_t          cmd,
  input  logic [dfsl_pkg::VTX_W-1:0]   label_raddr,
  output logic [dfsl_pkg::LABEL_W-1:0] label_rdata,
  output logic                         done
);
  import dfsl_pkg::*;

  typedef enum logic [1:0] {W_IDLE, W_ROW, W_SCAN, W_POP} wstate_t;

  wstate_t state;

  logic [EDGE_W-1:0]  adj_mem [MAX_VERTICES];
  logic [MAX_VERTICES-1:0] adj_valid;
  logic [EDGE_W-1:0]  adj_rdata;
  logic               adj_rvld;
  logic [VTX_W-1:0]   adj_raddr;

  frame_t             stack_mem [MAX_VERTICES];
  frame_t             stack_rdata;
  frame_t             stack_wdata;
  logic               stack_we;

  logic [LABEL_W-1:0] label_mem [MAX_VERTICES];
  logic               label_we;
  logic [VTX_W-1:0]   label_waddr;
  logic [LABEL_W-1:0] label_wdata;
  logic [LABEL_W-1:0] label_q;
  logic               label_vis;

  logic [MAX_VERTICES-1:0] visited;
  logic [VTX_W-1:0]   cur_v;
  logic [CNT_W-1:0]   cur_nx;
  logic [CNT_W-1:0]   sp;
  logic [CNT_W-1:0]   sp_m1;
  logic [CNT_W-1:0]   sp_m2;
  logic [EDGE_W-1:0]  row;
  logic [VTX_W-1:0]   nx_idx;
  logic               scan_end;
  logic               hit;
  logic               root_ok;

  assign nx_idx   = cur_nx[VTX_W-1:0];
  assign sp_m1    = sp - CNT_W'(1);
  assign sp_m2    = sp - CNT_W'(2);
  assign scan_end = cur_nx >= cmd.n;
  assign hit      = row[nx_idx] && !visited[nx_idx] && (sp < CNT_W'(MAX_VERTICES));
  assign root_ok  = {1'b0, cmd.root} < cmd.n;
  assign stack_we = (state == W_SCAN) && !scan_end && hit;
  assign stack_wdata = '{v: cur_v, nx: cur_nx + CNT_W'(1)};

  always_comb begin
    unique case (state)
      W_IDLE:  adj_raddr = cmd.root;
      W_SCAN:  adj_raddr = nx_idx;
      W_POP:   adj_raddr = stack_rdata.v;
      default: adj_raddr = cur_v;
    endcase
  end

  always_comb begin
    label_we    = 1'b0;
    label_waddr = nx_idx;
    label_wdata = sp[LABEL_W-1:0] + LABEL_W'(1);
    if (state == W_IDLE && cmd.search && root_ok) begin
      label_we    = 1'b1;
      label_waddr = cmd.root;
      label_wdata = LABEL_W'(1);
    end else if (stack_we) begin
      label_we = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      adj_mem[cmd.row] <= cmd.edges;
    end
    adj_rdata <= adj_mem[adj_raddr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      adj_valid <= '0;
      adj_rvld  <= 1'b0;
    end else begin
      if (cmd.load) begin
        adj_valid[cmd.row] <= 1'b1;
      end
      adj_rvld <= adj_valid[adj_raddr];
    end
  end

  always_ff @(posedge clk) begin
    if (stack_we) begin
      stack_mem[sp_m1[VTX_W-1:0]] <= stack_wdata;
    end
    stack_rdata <= stack_mem[sp_m2[VTX_W-1:0]];
  end

  always_ff @(posedge clk) begin
    if (label_we) begin
      label_mem[label_waddr] <= label_wdata;
    end
    label_q   <= label_mem[label_raddr];
    label_vis <= visited[label_raddr];
  end

  assign label_rdata = label_vis ? label_q : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= W_IDLE;
      sp      <= '0;
      done    <= 1'b0;
      visited <= '0;
    end else begin
      done <= 1'b0;
      unique case (state)
        W_IDLE: begin
          if (cmd.search) begin
            cur_v  <= cmd.root;
            cur_nx <= '0;
            if (root_ok) begin
              visited <= MAX_VERTICES'(1) << cmd.root;
              sp      <= CNT_W'(1);
              state   <= W_ROW;
            end else begin
              visited <= '0;
              done    <= 1'b1;
            end
          end
        end
        W_ROW: begin
          row   <= adj_rvld ? adj_rdata : '0;
          state <= W_SCAN;
        end
        W_SCAN: begin
          if (scan_end) begin
            if (sp == CNT_W'(1)) begin
              sp    <= '0;
              done  <= 1'b1;
              state <= W_IDLE;
            end else begin
              sp    <= sp_m1;
              state <= W_POP;
            end
          end else if (hit) begin
            visited[nx_idx] <= 1'b1;
            cur_v           <= nx_idx;
            cur_nx          <= '0;
            sp              <= sp + CNT_W'(1);
            state           <= W_ROW;
          end else begin
            cur_nx <= cur_nx + CNT_W'(1);
          end
        end
        W_POP: begin
          cur_v  <= stack_rdata.v;
          cur_nx <= stack_rdata.nx;
          state  <= W_ROW;
        end
      endcase
    end
  end

endmodule

// ===== hw/rtl/dfs_depth_labeler_core.sv =====
// Top level of the depth-first labeler: request intake, configuration and label output.
//
// Usage:
//   req carries items. mode 0 stores row_edges as the outgoing edges of
//   row_index; such a request leaves the core ready and any number may follow
//   back to back. mode 1 runs a depth-first walk from start_vertex over the
//   first vertex_count vertices and then sends one label per vertex on lbl,
//   in ascending vertex order, last_label marking the final one.
//   A search fetches a row on each descent, scans one neighbour at a time and
//   on each return reads the stack and fetches a row; its pace is set by the
//   single adjacency read port. Labels then stream at one per cycle from the
//   label memory while the receiver is ready. req.ready is low from the search
//   request until its last label is loaded into the output register; it rises
//   while that label may still be waiting. A stalled receiver holds the output
//   register and freezes the stream. Reset clears the graph to no edges, sets
//   vertex_count to 32 and start_vertex to 0; it needs no clearing pass.
//   Configuration is written through cfg_we/cfg_index/cfg_data; the user must
//   do so only while idle, as the block does not enforce it.
`timescale 1ns / 1ps
module dfs_depth_labeler_core (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_we,
  input  logic [dfsl_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [dfsl_pkg::CFG_DATA_W-1:0] cfg_data,
  dfsl_req_if.sink                        req,
  dfsl_lbl_if.source                      lbl
);
  import dfsl_pkg::*;

  typedef enum logic [1:0] {T_IDLE, T_WALK, T_EMIT} tstate_t;

  tstate_t state;

  logic [CNT_W-1:0]   vertex_count;
  logic [VTX_W-1:0]   start_vertex;
  logic [CNT_W-1:0]   n_used;
  logic               req_take;
  walk_cmd_t          cmd;
  logic [VTX_W-1:0]   label_raddr;
  logic [LABEL_W-1:0] label_rdata;
  logic               walk_done;
  logic [VTX_W-1:0]   emit_idx;
  logic               emit_load;
  logic               emit_last;
  logic               out_valid;
  logic [VTX_W-1:0]   out_vertex;
  logic [LABEL_W-1:0] out_label;
  logic               out_last;

  always_comb begin
    if (vertex_count == '0) begin
      n_used = CNT_W'(1);
    end else if (vertex_count > CNT_W'(MAX_VERTICES)) begin
      n_used = CNT_W'(MAX_VERTICES);
    end else begin
      n_used = vertex_count;
    end
  end

  assign req.ready = (state == T_IDLE);
  assign req_take  = req.valid && req.ready;

  assign cmd.load   = req_take && (req.mode == MODE_LOAD);
  assign cmd.search = req_take && (req.mode == MODE_SEARCH);
  assign cmd.row    = req.row_index;
  assign cmd.edges  = req.row_edges;
  assign cmd.n      = n_used;
  assign cmd.root   = start_vertex;

  assign emit_load = (state == T_EMIT) && (!out_valid || lbl.ready);
  assign emit_last = ({1'b0, emit_idx} + CNT_W'(1)) == n_used;

  always_comb begin
    if (state == T_EMIT) begin
      label_raddr = emit_load ? emit_idx + VTX_W'(1) : emit_idx;
    end else begin
      label_raddr = '0;
    end
  end

  dfsl_walk u_walk (
    .clk         (clk),
    .rst         (rst),
    .cmd         (cmd),
    .label_raddr (label_raddr),
    .label_rdata (label_rdata),
    .done        (walk_done)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      vertex_count <= CNT_W'(MAX_VERTICES);
      start_vertex <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_VERTEX_COUNT: vertex_count <= cfg_data[CNT_W-1:0];
        CFG_START_VERTEX: start_vertex <= cfg_data[VTX_W-1:0];
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= T_IDLE;
      emit_idx  <= '0;
      out_valid <= 1'b0;
    end else begin
      if (lbl.ready) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        T_IDLE: begin
          if (cmd.search) begin
            state <= T_WALK;
          end
        end
        T_WALK: begin
          emit_idx <= '0;
          if (walk_done) begin
            state <= T_EMIT;
          end
        end
        T_EMIT: begin
          if (emit_load) begin
            out_valid  <= 1'b1;
            out_vertex <= emit_idx;
            out_label  <= label_rdata;
            out_last   <= emit_last;
            emit_idx   <= emit_idx + VTX_W'(1);
            if (emit_last) begin
              state <= T_IDLE;
            end
          end
        end
        default: state <= T_IDLE;
      endcase
    end
  end

  assign lbl.valid       = out_valid;
  assign lbl.vertex_id   = out_vertex;
  assign lbl.depth_label = out_label;
  assign lbl.last_label  = out_last;

endmodule

// ===== hw/rtl/dfsl_checker.sv =====
// Port-level checks for the depth-first labeler, bound to the top level.
`timescale 1ns / 1ps
module dfsl_checker (
  input logic                            clk,
  input logic                            rst,
  input logic                            req_valid,
  input logic                            req_ready,
  input logic                            req_mode,
  input logic                            lbl_valid,
  input logic                            lbl_ready,
  input logic [dfsl_pkg::VTX_W-1:0]      lbl_vertex_id,
  input logic                            lbl_last_label
);
  import dfsl_pkg::*;

  a_lbl_hold: assert property (@(posedge clk) disable iff (rst)
    lbl_valid && !lbl_ready |=> lbl_valid)
    else $error("label dropped while stalled");

  a_busy_after_search: assert property (@(posedge clk) disable iff (rst)
    req_valid && req_ready && (req_mode == MODE_SEARCH) |=> !req_ready)
    else $error("request taken during search");

  a_load_keeps_ready: assert property (@(posedge clk) disable iff (rst)
    req_valid && req_ready && (req_mode == MODE_LOAD) |=> req_ready)
    else $error("row load stalled the request side");

  a_no_req_mid_stream: assert property (@(posedge clk) disable iff (rst)
    lbl_valid && !lbl_last_label |-> !req_ready)
    else $error("request side open before last label");

  a_ascending_ids: assert property (@(posedge clk) disable iff (rst)
    lbl_valid && lbl_ready && !lbl_last_label ##1 lbl_valid
      |-> lbl_vertex_id == $past(lbl_vertex_id) + VTX_W'(1))
    else $error("labels out of vertex order");

endmodule

bind dfs_depth_labeler_core dfsl_checker u_dfsl_checker (
  .clk            (clk),
  .rst            (rst),
  .req_valid      (req.valid),
  .req_ready      (req.ready),
  .req_mode       (req.mode),
  .lbl_valid      (lbl.valid),
  .lbl_ready      (lbl.ready),
  .lbl_vertex_id  (lbl.vertex_id),
  .lbl_last_label (lbl.last_label)
);
